// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/ccsd_pkg.sv =====
package ccsd_pkg;

    localparam int MAX_COEFFS = 1024;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int LIMIT_W  = 11;
    localparam int MAG_W    = 12;
    localparam int COEF_W   = 12;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 12;
    localparam int UNUSED_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_TRUNCATED = 3'd1;
    localparam t_status ST_UNARY     = 3'd2;
    localparam t_status ST_OVER      = 3'd3;
    localparam t_status ST_NEG_ZERO  = 3'd4;
    localparam t_status ST_TRAILING  = 3'd5;

    localparam t_cfg_idx CFG_COEFF_COUNT = 2'd0;
    localparam t_cfg_idx CFG_MAG_LIMIT   = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd512;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd2047;
    localparam logic [BYTES_W-1:0] BYTES_MAX   = 12'd4095;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_COEFFS);

endpackage

// ===== sv/compressed_coeff_stream_decoder.sv =====
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+---------------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_byte_value, i_last_byte
// out      | output    | o_out_valid / i_out_ready | o_has_coefficient, o_coefficient,
//          |           |                          | o_coeff_index, o_finished, o_status,
//          |           |                          | o_bytes_used, o_unused_bits
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte can be taken every cycle while the output is not stalled. The walk over its
// eight bits runs between the input register and the output register, which presents its result.
// Reset (synchronous, active low) clears the decoder state, both valid flags and
// loads the configuration defaults. A stalled output holds both registers, so input
// ready drops once the input register is full; it frees in the cycle the output drains.
module compressed_coeff_stream_decoder
    import ccsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_W-1:0]    i_byte_value,
    input  logic                 i_last_byte,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_has_coefficient,
    output logic signed [COEF_W-1:0] o_coefficient,
    output logic [INDEX_W-1:0]   o_coeff_index,
    output logic                 o_finished,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTES_W-1:0]   o_bytes_used,
    output logic [UNUSED_W-1:0]  o_unused_bits,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [COUNT_W-1:0] r_coeff_count;
    logic [LIMIT_W-1:0] r_mag_limit;

    // Input register.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;

    // Decoder state carried from byte to byte.
    logic [BYTE_W-1:0]  r_pend_bits, n_pend_bits;
    logic [3:0]         r_pend_cnt,  n_pend_cnt;
    logic               r_in_unary,  n_in_unary;
    logic               r_sign,      n_sign;
    logic [MAG_W-1:0]   r_mag,       n_mag;
    logic [COUNT_W-1:0] r_coeff_cnt, n_coeff_cnt;
    logic [BYTES_W-1:0] r_byte_cnt,  n_byte_cnt;
    logic               r_halted,    n_halted;

    // Output register.
    logic               r_out_valid;
    logic               r_has;
    logic [COEF_W-1:0]  r_coef;
    logic [INDEX_W-1:0] r_idx;
    logic               r_fin;
    t_status            r_status;
    logic [BYTES_W-1:0] r_used;
    logic [UNUSED_W-1:0] r_unused;

    // Results of the bit walk for the byte in the input register.
    logic               n_has;
    logic [COEF_W-1:0]  n_coef;
    logic [INDEX_W-1:0] n_idx;
    logic               n_fin;
    t_status            n_status;
    logic [BYTES_W-1:0] n_used;
    logic [UNUSED_W-1:0] n_unused;

    logic               advance;
    logic [COUNT_W-1:0] target;

    // The byte in the input register is processed whenever the output register
    // can take whatever it produces.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // A count of zero decodes one coefficient; large counts clamp to the maximum.
    always_comb begin
        if (r_coeff_count == '0) begin
            target = COUNT_W'(1);
        end else if (r_coeff_count > COUNT_MAX) begin
            target = COUNT_MAX;
        end else begin
            target = r_coeff_count;
        end
    end

    // Walk the eight bits of the byte, most significant first. At most one
    // coefficient can complete per byte, since a coefficient spans nine bits.
    always_comb begin
        logic [BYTE_W-1:0]  pb;
        logic [3:0]         pc;
        logic               iu;
        logic               sg;
        logic [MAG_W-1:0]   mg;
        logic [COUNT_W-1:0] cc;
        logic [BYTES_W-1:0] bc;
        logic [BYTE_W-1:0]  low_mask;
        logic               bit_v;

        pb = r_pend_bits;
        pc = r_pend_cnt;
        iu = r_in_unary;
        sg = r_sign;
        mg = r_mag;
        cc = r_coeff_cnt;
        bc = (r_byte_cnt < BYTES_MAX) ? r_byte_cnt + BYTES_W'(1) : r_byte_cnt;
        low_mask = '0;
        bit_v    = 1'b0;

        n_has    = 1'b0;
        n_coef   = '0;
        n_idx    = '0;
        n_fin    = 1'b0;
        n_status = ST_OK;
        n_used   = '0;
        n_unused = '0;

        for (int i = BYTE_W - 1; i >= 0; i--) begin
            bit_v    = r_byte[i];
            low_mask = BYTE_W'((9'd1 << i) - 9'd1);
            if (!n_fin) begin
                if (!iu) begin
                    // Gather the sign and seven low magnitude bits.
                    pb = {pb[BYTE_W-2:0], bit_v};
                    pc = pc + 4'd1;
                    if (pc >= 4'd8) begin
                        sg = pb[BYTE_W-1];
                        mg = {5'b0, pb[BYTE_W-2:0]};
                        iu = 1'b1;
                        pb = '0;
                        pc = '0;
                    end
                end else if (bit_v) begin
                    // Terminating one of the unary part.
                    iu = 1'b0;
                    if (sg && mg == '0) begin
                        n_fin    = 1'b1;
                        n_status = ST_NEG_ZERO;
                    end else begin
                        n_has  = 1'b1;
                        n_coef = sg ? (COEF_W'(0) - mg) : mg;
                        n_idx  = cc[INDEX_W-1:0];
                        cc     = cc + COUNT_W'(1);
                        if (cc >= target) begin
                            n_fin = 1'b1;
                            if ((r_byte & low_mask) != '0) begin
                                n_status = ST_TRAILING;
                            end else begin
                                n_status = ST_OK;
                                n_used   = bc;
                                n_unused = UNUSED_W'(i);
                            end
                        end
                    end
                end else begin
                    mg = mg + MAG_W'(128);
                    if (mg > {1'b0, r_mag_limit}) begin
                        n_fin    = 1'b1;
                        n_status = ST_OVER;
                    end
                end
            end
        end

        if (!n_fin && r_last) begin
            n_fin    = 1'b1;
            n_status = iu ? ST_UNARY : ST_TRUNCATED;
        end

        // A last byte always rearms; a halted decoder otherwise keeps its state.
        if (r_last) begin
            n_pend_bits = '0;
            n_pend_cnt  = '0;
            n_in_unary  = 1'b0;
            n_sign      = 1'b0;
            n_mag       = '0;
            n_coeff_cnt = '0;
            n_byte_cnt  = '0;
            n_halted    = 1'b0;
        end else if (r_halted) begin
            n_pend_bits = r_pend_bits;
            n_pend_cnt  = r_pend_cnt;
            n_in_unary  = r_in_unary;
            n_sign      = r_sign;
            n_mag       = r_mag;
            n_coeff_cnt = r_coeff_cnt;
            n_byte_cnt  = r_byte_cnt;
            n_halted    = 1'b1;
        end else begin
            n_pend_bits = pb;
            n_pend_cnt  = pc;
            n_in_unary  = iu;
            n_sign      = sg;
            n_mag       = mg;
            n_coeff_cnt = cc;
            n_byte_cnt  = bc;
            n_halted    = n_fin;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_count <= COUNT_RESET;
            r_mag_limit   <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COEFF_COUNT: r_coeff_count <= i_cfg_data;
                CFG_MAG_LIMIT:   r_mag_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_byte_value;
            r_last <= i_last_byte;
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_in_unary  <= 1'b0;
            r_sign      <= 1'b0;
            r_mag       <= '0;
            r_coeff_cnt <= '0;
            r_byte_cnt  <= '0;
            r_halted    <= 1'b0;
        end else if (advance) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_in_unary  <= n_in_unary;
            r_sign      <= n_sign;
            r_mag       <= n_mag;
            r_coeff_cnt <= n_coeff_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_halted    <= n_halted;
        end
    end

    // Output register. A halted decoder produces no result for its byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= !r_halted && (n_has || n_fin);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_has    <= n_has;
            r_coef   <= n_coef;
            r_idx    <= n_idx;
            r_fin    <= n_fin;
            r_status <= n_status;
            r_used   <= n_used;
            r_unused <= n_unused;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_has_coefficient = r_has;
    assign o_coefficient     = r_coef;
    assign o_coeff_index     = r_idx;
    assign o_finished        = r_fin;
    assign o_status          = r_status;
    assign o_bytes_used      = r_used;
    assign o_unused_bits     = r_unused;

endmodule

// ===== sv/ccsd_checker.sv =====
`include "assert_macros.svh"

module ccsd_checker
    import ccsd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_has_coefficient,
    input logic [COEF_W-1:0]    o_coefficient,
    input logic [INDEX_W-1:0]   o_coeff_index,
    input logic                 o_finished,
    input logic [STATUS_W-1:0]  o_status,
    input logic [BYTES_W-1:0]   o_bytes_used,
    input logic [UNUSED_W-1:0]  o_unused_bits
);

    // A stalled item stays valid and keeps its coefficient, status and finish flag.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_coefficient) && $stable(o_status) && $stable(o_finished))

    // Every item carries a coefficient, a finish, or both.
    `ASSERT_SAME(a_out_content, i_clk, i_rst_n, o_out_valid,
        o_has_coefficient || o_finished)

    // Without a coefficient its fields read zero.
    `ASSERT_SAME(a_no_coef_zero, i_clk, i_rst_n, o_out_valid && !o_has_coefficient,
        o_coefficient == '0 && o_coeff_index == '0)

    // Only a successful finish reports bytes used and unused bits.
    `ASSERT_SAME(a_summary_ok_only, i_clk, i_rst_n,
        o_out_valid && (!o_finished || o_status != ST_OK),
        o_bytes_used == '0 && o_unused_bits == '0)

endmodule

bind compressed_coeff_stream_decoder ccsd_checker u_ccsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_has_coefficient (o_has_coefficient),
    .o_coefficient     (o_coefficient),
    .o_coeff_index     (o_coeff_index),
    .o_finished        (o_finished),
    .o_status          (o_status),
    .o_bytes_used      (o_bytes_used),
    .o_unused_bits     (o_unused_bits)
);
